// File: rtl/jddm_pkg.sv
// ----------------------------------------------------------------------------
// jddm_pkg
// Shared types and constants for the joystick differential drive mixer.
// ----------------------------------------------------------------------------
package jddm_pkg;

    localparam int unsigned PIVOT_LIMIT = 32;
    localparam int unsigned PREMIX_FULL = 127;
    localparam int unsigned CMD_MAX     = 90;
    localparam int unsigned TICKS_UNIT  = 14;
    localparam int unsigned DIV_BIAS    = 4095;
    localparam int unsigned RECIP_127   = 516;
    localparam int unsigned RECIP_SHIFT = 16;

    typedef logic signed [8:0]  premix_t;
    typedef logic signed [8:0]  pivot_t;
    typedef logic signed [7:0]  axis_t;
    typedef logic        [5:0]  weight_t;
    typedef logic signed [7:0]  cmd_t;
    typedef logic        [10:0] goal_t;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
        logic s7;
    } adv_t;

endpackage

// File: rtl/jddm_side.sv
// ----------------------------------------------------------------------------
// jddm_side
// One wheel datapath: blend quotient, scaling to +-90, reverse flag and goal.
// ----------------------------------------------------------------------------
module jddm_side
(
    input  logic                clk,
    input  jddm_pkg::adv_t      adv,
    input  jddm_pkg::premix_t   premix,
    input  jddm_pkg::pivot_t    pivot,
    input  jddm_pkg::axis_t     joy_y,
    input  jddm_pkg::weight_t   weight,
    output jddm_pkg::cmd_t      mix,
    output logic                reverse,
    output jddm_pkg::goal_t     goal
);

    logic signed [16:0] py_reg, py_next;
    jddm_pkg::weight_t  a2_reg;
    jddm_pkg::pivot_t   piv2_reg;

    logic signed [23:0] num_reg, num_next;
    logic signed [23:0] drive_term;
    logic signed [15:0] pivot_prod;
    logic signed [6:0]  pivot_wt;

    logic signed [23:0] biased;
    logic signed [8:0]  quot;
    logic        [8:0]  quot_mag;
    logic        [14:0] scaled;
    logic        [13:0] m4_reg, m4_next;
    logic               neg4_reg;

    logic        [23:0] recip_prod;
    logic        [7:0]  qe5_reg, qe5_next;
    logic        [13:0] m5_reg;
    logic               neg5_reg;

    logic        [13:0] qe_times;
    logic        [13:0] rem;
    logic        [7:0]  q6_reg, q6_next;
    logic               neg6_reg;

    logic        [7:0]  q_signed;
    logic        [11:0] goal_prod;
    jddm_pkg::cmd_t     mix_reg, mix_next;
    logic               rev_reg, rev_next;
    jddm_pkg::goal_t    goal_reg, goal_next;

    assign py_next = 17'(premix * joy_y);

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            py_reg   <= py_next;
            a2_reg   <= weight;
            piv2_reg <= pivot;
        end
    end

    always_comb
    begin
        drive_term = 24'($signed({1'b0, a2_reg}) * py_reg);
        pivot_wt   = 7'(jddm_pkg::PIVOT_LIMIT) - $signed({1'b0, a2_reg});
        pivot_prod = 16'(pivot_wt * piv2_reg);
        num_next   = drive_term + (24'(pivot_prod) <<< 7);
    end

    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            num_reg <= num_next;
        end
    end

    always_comb
    begin
        biased   = num_reg + (num_reg[23] ? 24'(jddm_pkg::DIV_BIAS) : 24'sd0);
        quot     = biased[20:12];
        quot_mag = quot[8] ? 9'(-quot) : 9'(quot);
        scaled   = 15'(quot_mag[7:0] * 7'(jddm_pkg::CMD_MAX));
        m4_next  = scaled[13:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv.s4)
        begin
            m4_reg   <= m4_next;
            neg4_reg <= quot[8];
        end
    end

    assign recip_prod = 24'(m4_reg * 10'(jddm_pkg::RECIP_127));
    assign qe5_next   = recip_prod[jddm_pkg::RECIP_SHIFT +: 8];

    always_ff @(posedge clk)
    begin
        if (adv.s5)
        begin
            qe5_reg  <= qe5_next;
            m5_reg   <= m4_reg;
            neg5_reg <= neg4_reg;
        end
    end

    // correct the reciprocal estimate by at most one
    always_comb
    begin
        qe_times = ({6'd0, qe5_reg} << 7) - {6'd0, qe5_reg};
        rem      = m5_reg - qe_times;
        q6_next  = (rem >= 14'(jddm_pkg::PREMIX_FULL)) ? qe5_reg + 8'd1 : qe5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv.s6)
        begin
            q6_reg   <= q6_next;
            neg6_reg <= neg5_reg;
        end
    end

    always_comb
    begin
        q_signed  = neg6_reg ? 8'(-q6_reg) : q6_reg;
        mix_next  = $signed(q_signed);
        rev_next  = neg6_reg && (q6_reg != 8'd0);
        goal_prod = 12'(q6_reg * 4'(jddm_pkg::TICKS_UNIT));
        goal_next = goal_prod[10:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv.s7)
        begin
            mix_reg  <= mix_next;
            rev_reg  <= rev_next;
            goal_reg <= goal_next;
        end
    end

    assign mix     = mix_reg;
    assign reverse = rev_reg;
    assign goal    = goal_reg;

endmodule

// File: rtl/joystick_differential_drive_mixer_unit.sv
// ----------------------------------------------------------------------------
// joystick_differential_drive_mixer_unit
// Joystick X/Y to left/right wheel commands, reverse flags and goal speeds.
//
//  channel   dir  payload
//  s_axis    in   tdata[15:0]: joy_x, joy_y
//  m_axis    out  tdata[39:0]: left/right mix, reverse flags, goals
//
// Seven register stages; one request per cycle while m_axis is not stalled.
// The blend multiply stage and the reciprocal divide-by-127 stages are
// pipelined like the rest, so only m_axis back-pressure holds the flow.
// Reset clears the stage valid bits only.
// A stall on m_axis holds every full stage; empty stages still fill.
// ----------------------------------------------------------------------------
module joystick_differential_drive_mixer_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // joy_x[7:0], joy_y[15:8]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // left_mix[7:0], right_mix[15:8],
                                        // left_reverse[16], right_reverse[17],
                                        // left_goal[28:18], right_goal[39:29]
);

    localparam int unsigned STAGES = 7;

    logic [STAGES:1]   valid_reg;
    logic [STAGES+1:1] ready;
    logic [STAGES-1:0] valid_in;
    jddm_pkg::adv_t    adv;

    jddm_pkg::axis_t    joy_x, joy_y;
    logic signed [8:0]  xe;
    logic        [8:0]  ay;
    jddm_pkg::premix_t  pl_next, pr_next;
    jddm_pkg::weight_t  a_next;

    jddm_pkg::premix_t  pl_reg, pr_reg;
    jddm_pkg::pivot_t   pvl_reg, pvr_reg;
    jddm_pkg::axis_t    y_reg;
    jddm_pkg::weight_t  a_reg;

    jddm_pkg::cmd_t     left_mix, right_mix;
    logic               left_reverse, right_reverse;
    jddm_pkg::goal_t    left_goal, right_goal;

    always_comb
    begin
        ready[STAGES+1] = m_axis_tready;
        valid_in[0]     = s_axis_tvalid;
        for (int k = STAGES; k >= 1; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
        for (int k = 1; k < STAGES; k++)
        begin
            valid_in[k] = valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= STAGES; k++)
            begin
                if (ready[k])
                begin
                    valid_reg[k] <= valid_in[k-1];
                end
            end
        end
    end

    assign adv = '{s2: ready[2], s3: ready[3], s4: ready[4],
                   s5: ready[5], s6: ready[6], s7: ready[7]};

    always_comb
    begin
        joy_x  = s_axis_tdata[7:0];
        joy_y  = s_axis_tdata[15:8];
        xe     = 9'(joy_x);
        ay     = joy_y[7] ? 9'(-9'(joy_y)) : 9'(joy_y);
        a_next = (ay > 9'(jddm_pkg::PIVOT_LIMIT)) ? 6'(jddm_pkg::PIVOT_LIMIT) : ay[5:0];
        if (!joy_y[7])
        begin
            pl_next = joy_x[7] ? 9'(jddm_pkg::PREMIX_FULL) + xe : 9'(jddm_pkg::PREMIX_FULL);
            pr_next = joy_x[7] ? 9'(jddm_pkg::PREMIX_FULL) : 9'(jddm_pkg::PREMIX_FULL) - xe;
        end
        else
        begin
            pl_next = joy_x[7] ? 9'(jddm_pkg::PREMIX_FULL) : 9'(jddm_pkg::PREMIX_FULL) - xe;
            pr_next = joy_x[7] ? 9'(jddm_pkg::PREMIX_FULL) + xe : 9'(jddm_pkg::PREMIX_FULL);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[1])
        begin
            pl_reg  <= pl_next;
            pr_reg  <= pr_next;
            pvl_reg <= xe;
            pvr_reg <= -xe;
            y_reg   <= joy_y;
            a_reg   <= a_next;
        end
    end

    jddm_side u_left
    (
        .clk     (clk),
        .adv     (adv),
        .premix  (pl_reg),
        .pivot   (pvl_reg),
        .joy_y   (y_reg),
        .weight  (a_reg),
        .mix     (left_mix),
        .reverse (left_reverse),
        .goal    (left_goal)
    );

    jddm_side u_right
    (
        .clk     (clk),
        .adv     (adv),
        .premix  (pr_reg),
        .pivot   (pvr_reg),
        .joy_y   (y_reg),
        .weight  (a_reg),
        .mix     (right_mix),
        .reverse (right_reverse),
        .goal    (right_goal)
    );

    assign s_axis_tready = ready[1];
    assign m_axis_tvalid = valid_reg[STAGES];
    assign m_axis_tdata  = {right_goal, left_goal, right_reverse, left_reverse,
                            right_mix, left_mix};

endmodule

// File: rtl/jddm_checker.sv
// ----------------------------------------------------------------------------
// jddm_checker
// Port-level checks for the joystick differential drive mixer.
// ----------------------------------------------------------------------------
module jddm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && !s_axis_tready) |=> (s_axis_tvalid && $stable(s_axis_tdata)))
        else $error("stalled request changed");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("empty output but input blocked");

    a_rev: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[16] == m_axis_tdata[7])
                        && (m_axis_tdata[17] == m_axis_tdata[15])))
        else $error("reverse flag disagrees with command sign");

    a_goal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[28:18] <= 11'd1260)
                        && (m_axis_tdata[39:29] <= 11'd1260)))
        else $error("goal out of range");

endmodule

bind joystick_differential_drive_mixer_unit jddm_checker u_jddm_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: tb/joystick_differential_drive_mixer_unit_tb.sv
// ----------------------------------------------------------------------------
// joystick_differential_drive_mixer_unit_tb
// Self-checking bench for the joystick to wheel command mixer.
// Each accepted joystick request is run through a local integer model of the
// premix, pivot blend, +-90 scaling and goal computation. The predicted wheel
// commands are queued, and every output request is checked field by field
// against the oldest one. Corner requests come first, then random ones under
// varying source and sink stalls, and then a long output stall that fills
// the pipeline.
// ----------------------------------------------------------------------------
module joystick_differential_drive_mixer_unit_tb;

    localparam int PIVOT_SPAN     = 32;
    localparam int PREMIX_TOP     = 127;
    localparam int THROTTLE_SCALE = 128;
    localparam int CMD_LIMIT      = 90;
    localparam int TICKS_PER_CMD  = 14;
    localparam int PIPE_DEPTH     = 7;
    localparam int HOLD_LEN       = 120;
    localparam int CYCLE_LIMIT    = 200000;

    typedef struct {
        jddm_pkg::cmd_t  left_mix;
        jddm_pkg::cmd_t  right_mix;
        logic            left_reverse;
        logic            right_reverse;
        jddm_pkg::goal_t left_goal;
        jddm_pkg::goal_t right_goal;
    } wheel_cmd_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    wheel_cmd_t  wheel_cmd_q[$];
    int          fail_count    = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        hold_req      = 1'b0;
    logic        hold_seen     = 1'b0;
    int          hold_left     = 0;

    joystick_differential_drive_mixer_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int blend_mix(int premix, int pivot, int y, int a);
        int num;
        num = a * premix * y + (PIVOT_SPAN - a) * THROTTLE_SCALE * pivot;
        return num / (PIVOT_SPAN * THROTTLE_SCALE);
    endfunction

    function automatic void scale_wheel(input int mix, output jddm_pkg::cmd_t cmd,
                                        output logic rev, output jddm_pkg::goal_t goal);
        int c;
        int mag;
        c    = mix * CMD_LIMIT / PREMIX_TOP;
        mag  = (c < 0) ? -c : c;
        cmd  = jddm_pkg::cmd_t'(c);
        rev  = (c < 0);
        goal = jddm_pkg::goal_t'(mag * TICKS_PER_CMD);
    endfunction

    function automatic wheel_cmd_t mix_wheels(jddm_pkg::axis_t jx, jddm_pkg::axis_t jy);
        int         x;
        int         y;
        int         ay;
        int         a;
        int         pl;
        int         pr;
        wheel_cmd_t r;
        x  = jx;
        y  = jy;
        ay = (y < 0) ? -y : y;
        a  = (ay > PIVOT_SPAN) ? PIVOT_SPAN : ay;
        if (y >= 0)
        begin
            pl = (x >= 0) ? PREMIX_TOP : PREMIX_TOP + x;
            pr = (x >= 0) ? PREMIX_TOP - x : PREMIX_TOP;
        end
        else
        begin
            pl = (x >= 0) ? PREMIX_TOP - x : PREMIX_TOP;
            pr = (x >= 0) ? PREMIX_TOP : PREMIX_TOP + x;
        end
        scale_wheel(blend_mix(pl, x, y, a), r.left_mix, r.left_reverse, r.left_goal);
        scale_wheel(blend_mix(pr, -x, y, a), r.right_mix, r.right_reverse, r.right_goal);
        return r;
    endfunction

    // Predict on every accepted joystick request.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            wheel_cmd_q.push_back(mix_wheels(s_axis_tdata[7:0], s_axis_tdata[15:8]));
    end

    // Check every accepted wheel command request.
    always @(posedge clk)
    begin
        wheel_cmd_t exp_cmd;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (wheel_cmd_q.size() == 0)
            begin
                $error("unexpected wheel command request: %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                exp_cmd = wheel_cmd_q.pop_front();
                if (m_axis_tdata[7:0] !== exp_cmd.left_mix)
                begin
                    $error("left_mix expected %0d got %0d",
                           exp_cmd.left_mix, $signed(m_axis_tdata[7:0]));
                    fail_count++;
                end
                if (m_axis_tdata[15:8] !== exp_cmd.right_mix)
                begin
                    $error("right_mix expected %0d got %0d",
                           exp_cmd.right_mix, $signed(m_axis_tdata[15:8]));
                    fail_count++;
                end
                if (m_axis_tdata[16] !== exp_cmd.left_reverse)
                begin
                    $error("left_reverse expected %0d got %0d",
                           exp_cmd.left_reverse, m_axis_tdata[16]);
                    fail_count++;
                end
                if (m_axis_tdata[17] !== exp_cmd.right_reverse)
                begin
                    $error("right_reverse expected %0d got %0d",
                           exp_cmd.right_reverse, m_axis_tdata[17]);
                    fail_count++;
                end
                if (m_axis_tdata[28:18] !== exp_cmd.left_goal)
                begin
                    $error("left_goal expected %0d got %0d",
                           exp_cmd.left_goal, m_axis_tdata[28:18]);
                    fail_count++;
                end
                if (m_axis_tdata[39:29] !== exp_cmd.right_goal)
                begin
                    $error("right_goal expected %0d got %0d",
                           exp_cmd.right_goal, m_axis_tdata[39:29]);
                    fail_count++;
                end
            end
        end
    end

    // Output sink: random stalls, or a long hold when one is requested.
    always @(posedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen     <= hold_req;
            hold_left     <= HOLD_LEN;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_joystick(input jddm_pkg::axis_t jx, input jddm_pkg::axis_t jy);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 16'($urandom);
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {jy, jx};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic send_random_joystick();
        jddm_pkg::axis_t jx;
        jddm_pkg::axis_t jy;
        case ($urandom_range(9))
            0:       jx = 8'sh80;
            1:       jx = 8'sh7f;
            default: jx = jddm_pkg::axis_t'($urandom);
        endcase
        // favor the pivot blend region
        if ($urandom_range(99) < 40)
            jy = jddm_pkg::axis_t'(int'($urandom_range(64)) - 32);
        else
            jy = jddm_pkg::axis_t'($urandom);
        send_joystick(jx, jy);
    endtask

    task automatic test_axis_extremes();
        send_joystick(8'sd0,    8'sd0);
        send_joystick(8'sd127,  8'sd127);
        send_joystick(-8'sd128, -8'sd128);
        send_joystick(8'sd127,  -8'sd128);
        send_joystick(-8'sd128, 8'sd127);
        send_joystick(-8'sd128, 8'sd0);
        send_joystick(8'sd127,  8'sd0);
        send_joystick(8'sd0,    8'sd127);
        send_joystick(8'sd0,    -8'sd128);
        send_joystick(-8'sd1,   -8'sd1);
        send_joystick(8'sd1,    8'sd1);
        send_joystick(8'sh55,   8'sh2a);
        send_joystick(-8'sd86,  -8'sd43);
    endtask

    task automatic test_pivot_boundary();
        send_joystick(8'sd64,   8'sd31);
        send_joystick(8'sd64,   8'sd32);
        send_joystick(8'sd64,   8'sd33);
        send_joystick(-8'sd64,  -8'sd31);
        send_joystick(-8'sd64,  -8'sd32);
        send_joystick(-8'sd128, 8'sd16);
        send_joystick(-8'sd128, -8'sd16);
        send_joystick(8'sd127,  -8'sd1);
        send_joystick(8'sd100,  8'sd0);
    endtask

    task automatic test_random_mix(input int n, input int src_pct, input int snk_pct);
        send_idle_pct = src_pct;
        recv_idle_pct = snk_pct;
        repeat (n) send_random_joystick();
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = ~hold_req;
        repeat (40) send_random_joystick();
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_axis_extremes();
        test_pivot_boundary();
        test_random_mix(220, 6, 62);
        test_random_mix(220, 62, 6);
        test_random_mix(220, 0, 0);
        test_output_backpressure();

        s_axis_tvalid <= 1'b0;
        while (wheel_cmd_q.size() != 0) @(posedge clk);
        repeat (3 * PIPE_DEPTH) @(posedge clk);

        if (fail_count == 0 && wheel_cmd_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/jddm_pkg.sv
rtl/jddm_side.sv
rtl/joystick_differential_drive_mixer_unit.sv
rtl/jddm_checker.sv
tb/joystick_differential_drive_mixer_unit_tb.sv
